[rtl/cfei_pkg.sv]
// Shared status codes for the coalescing free-extent table.
// No dependencies.
`default_nettype none
package cfei_pkg;
    localparam int STATUS_W = 3;
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED     = 3'd0,
        ST_MERGED_AFTER = 3'd1,
        ST_MERGED_BEFORE = 3'd2,
        ST_MERGED_BOTH  = 3'd3,
        ST_FULL_DROP    = 3'd4
    } t_status;
endpackage
`default_nettype wire

[rtl/coalescing_free_extent_insert.sv]
// Top level of the address-ordered free-extent table with coalescing.
// Uses cfei_pkg for the status codes.
//
// One freed extent (start, size) arrives per input transfer and one result transfer
// leaves per item. The table sits in one synchronous memory with one read and one
// write port, holding {length,start} per entry in address order. The search reads
// entries one per cycle until the first start not below the freed start, then the
// block merges, inserts or drops. An insert moves the tail up one entry, and a merge
// of both neighbors moves it down one entry; each moved entry is read, then written.
// A new input is taken only once the result of the last one has been transferred,
// so a stall on the result side holds the input side too. A read and a write never
// touch the same entry in one cycle, so no forwarding is needed. No clearing pass
// is needed: entries at or above the count never reach a result.
`default_nettype none
module coalescing_free_extent_insert #(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata: free_start[AB-1:0], free_size[2AB-1:AB], zero filled to bytes
    input  wire logic [((2*ADDR_BITS)+7)/8*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata: status[2:0], result_start, result_length(AB+1), extent_total
    output logic [((3+ADDR_BITS+ADDR_BITS+1+$clog2(MAX_EXTENTS+1))+7)/8*8-1:0]
                      m_axis_tdata
);
    import cfei_pkg::*;

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS+1);
    localparam int LW = ADDR_BITS + 1;
    localparam int EW = ADDR_BITS + LW;
    localparam int OW = ((3+ADDR_BITS+LW+CW)+7)/8*8;
    localparam logic [LW-1:0] LEN_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_MV_RD, S_MV_WR, S_PUT, S_OUT
    } t_state;

    logic [EW-1:0] r_mem [MAX_EXTENTS];
    logic [EW-1:0] r_rdata;
    logic [IW-1:0] n_raddr;
    logic          n_rd;
    logic          n_we;
    logic [IW-1:0] n_waddr;
    logic [EW-1:0] n_wdata;

    t_state               r_state;
    logic [CW-1:0]        r_cnt, r_idx, r_ptr;
    logic [ADDR_BITS-1:0] r_s, r_z;
    logic [ADDR_BITS-1:0] r_pst;        // preceding entry start
    logic [LW-1:0]        r_plen;       // preceding entry length
    logic [LW-1:0]        r_nlen;       // following entry length
    logic                 r_before, r_after, r_up;
    t_status              r_st;
    logic [ADDR_BITS-1:0] r_ost;
    logic [LW-1:0]        r_olen;

    function automatic logic [LW-1:0] sat(input logic [LW+1:0] v);
        return (v > {2'b0, LEN_MAX}) ? LEN_MAX : v[LW-1:0];
    endfunction

    wire [ADDR_BITS-1:0] rd_st  = r_rdata[ADDR_BITS-1:0];
    wire [LW-1:0]        rd_len = r_rdata[EW-1:ADDR_BITS];
    wire [ADDR_BITS:0]   s_end  = {1'b0, r_s} + {1'b0, r_z};
    wire [LW:0]          p_end  = {2'b0, r_pst} + {1'b0, r_plen};
    wire [CW-1:0]        idx_p1 = r_idx + 1'b1;
    wire [CW-1:0]        idx_m1 = r_idx - 1'b1;
    wire [CW-1:0]        ptr_p1 = r_ptr + 1'b1;
    wire [CW-1:0]        ptr_m1 = r_ptr - 1'b1;
    // Move another entry: upward until the hole reaches idx, downward until the
    // hole reaches the end of the shortened table
    wire                 mv_go  = r_up ? (r_ptr > r_idx) : (r_ptr < r_cnt);

    wire [LW-1:0] len_both   = sat({2'b0, r_plen} + {3'b0, r_z} + {2'b0, r_nlen});
    wire [LW-1:0] len_before = sat({2'b0, r_plen} + {3'b0, r_z});
    wire [LW-1:0] len_after  = sat({2'b0, r_nlen} + {3'b0, r_z});

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        if (n_rd) r_rdata <= r_mem[n_raddr];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OW'({r_cnt, r_olen, r_ost, r_st});

    always_comb begin
        n_rd = 1'b0; n_raddr = '0; n_we = 1'b0; n_waddr = '0; n_wdata = '0;
        unique case (r_state)
            // Prefetch entry 0 so the search starts right after the transfer
            S_IDLE: begin
                n_rd = 1'b1; n_raddr = '0;
            end
            S_SEARCH: begin
                n_rd = (idx_p1 < r_cnt); n_raddr = idx_p1[IW-1:0];
            end
            S_DECIDE: begin
                priority if (r_before && r_after) begin
                    n_we = 1'b1; n_waddr = idx_m1[IW-1:0];
                    n_wdata = {len_both, r_pst};
                end else if (r_before) begin
                    n_we = 1'b1; n_waddr = idx_m1[IW-1:0];
                    n_wdata = {len_before, r_pst};
                end else if (r_after) begin
                    n_we = 1'b1; n_waddr = r_idx[IW-1:0];
                    n_wdata = {len_after, r_s};
                end else begin
                    n_we = 1'b0;
                end
            end
            S_MV_RD: begin
                n_rd = mv_go;
                n_raddr = r_up ? ptr_m1[IW-1:0] : ptr_p1[IW-1:0];
            end
            S_MV_WR: begin
                n_we = 1'b1; n_waddr = r_ptr[IW-1:0]; n_wdata = r_rdata;
            end
            S_PUT: begin
                n_we = 1'b1; n_waddr = r_idx[IW-1:0]; n_wdata = {1'b0, r_z, r_s};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_s <= s_axis_tdata[ADDR_BITS-1:0];
                    r_z <= s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS];
                    r_idx <= '0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    // rdata holds entry r_idx; stop at first start >= freed start
                    if (r_idx < r_cnt && rd_st < r_s) begin
                        r_pst <= rd_st; r_plen <= rd_len;
                        r_idx <= idx_p1;
                    end else begin
                        r_after  <= (r_idx < r_cnt) && (s_end == {1'b0, rd_st});
                        r_before <= (r_idx != '0) && (p_end == {2'b0, r_s});
                        r_nlen   <= rd_len;
                        r_state  <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    priority if (r_before && r_after) begin
                        // Fold the following entry into the preceding one, close the gap
                        r_st <= ST_MERGED_BOTH; r_ost <= r_pst; r_olen <= len_both;
                        r_up <= 1'b0; r_ptr <= r_idx;
                        r_cnt <= r_cnt - 1'b1;
                        r_state <= S_MV_RD;
                    end else if (r_before) begin
                        r_st <= ST_MERGED_BEFORE; r_ost <= r_pst; r_olen <= len_before;
                        r_state <= S_OUT;
                    end else if (r_after) begin
                        r_st <= ST_MERGED_AFTER; r_ost <= r_s; r_olen <= len_after;
                        r_state <= S_OUT;
                    end else if (r_cnt >= CW'(MAX_EXTENTS)) begin
                        // Drop the extent, table unchanged
                        r_st <= ST_FULL_DROP; r_ost <= '0; r_olen <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // Open a hole at idx by moving the tail up from the end
                        r_st <= ST_INSERTED; r_ost <= r_s; r_olen <= {1'b0, r_z};
                        r_up <= 1'b1; r_ptr <= r_cnt;
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= S_MV_RD;
                    end
                end
                S_MV_RD: begin
                    if (mv_go) r_state <= S_MV_WR;
                    else if (r_up) r_state <= S_PUT;
                    else r_state <= S_OUT;
                end
                S_MV_WR: begin
                    r_ptr <= r_up ? ptr_m1 : ptr_p1;
                    r_state <= S_MV_RD;
                end
                S_PUT: r_state <= S_OUT;
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_EXTENTS));
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid));
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_st <= ST_FULL_DROP));
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the coalescing free-extent table.
// Depends on cfei_pkg and coalescing_free_extent_insert from the RTL.
`timescale 1ns / 1ps
module testbench;
    import cfei_pkg::*;

    localparam int MAX_EXT = 64;
    localparam int ABITS   = 16;
    localparam int LEN_TOP = (1 << (ABITS + 1)) - 1;
    localparam int N_RAND  = 890;
    localparam int N_QUIET = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        t_status     status;
        logic [15:0] start;
        logic [16:0] length;
        logic [6:0]  total;
    } t_outcome;

    typedef struct {
        logic [15:0] start;
        logic [15:0] size;
        bit          typed;
        t_outcome    outcome;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: free_start[15:0], free_size[31:16]
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: status[2:0], result_start[18:3], result_length[35:19],
    //        extent_total[42:36], zero fill above
    logic [47:0] m_axis_tdata;

    // Shadow copy of the free-extent table
    logic [15:0] tbl_start [MAX_EXT];
    logic [16:0] tbl_len   [MAX_EXT];
    int          tbl_count;

    t_outcome pending_results[$];
    int       errors;
    int       n_sent;
    int       n_recv;
    int       n_merged;
    int       n_dropped;
    bit       quiet;
    int       cycles;

    coalescing_free_extent_insert u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results still expected",
                     $time, cycles, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Apply one free to the shadow table and return the result it should give.
    function automatic t_outcome coalesce_free(logic [15:0] fs, logic [15:0] fz);
        t_outcome r;
        int pos;
        int sum;
        bit touch_next;
        bit touch_prev;
        pos = 0;
        while (pos < tbl_count && tbl_start[pos] < fs) pos++;
        // End address computed wide, so nothing wraps past the top
        touch_next = (pos < tbl_count) && (int'(fs) + int'(fz) == int'(tbl_start[pos]));
        touch_prev = (pos > 0) &&
                     (int'(tbl_start[pos-1]) + int'(tbl_len[pos-1]) == int'(fs));
        if (touch_prev && touch_next) begin
            sum = int'(tbl_len[pos-1]) + int'(fz) + int'(tbl_len[pos]);
            tbl_len[pos-1] = (sum > LEN_TOP) ? LEN_TOP[16:0] : sum[16:0];
            for (int i = pos; i + 1 < tbl_count; i++) begin
                tbl_start[i] = tbl_start[i+1];
                tbl_len[i]   = tbl_len[i+1];
            end
            tbl_count--;
            r = '{ST_MERGED_BOTH, tbl_start[pos-1], tbl_len[pos-1], 7'(tbl_count)};
        end else if (touch_prev) begin
            sum = int'(tbl_len[pos-1]) + int'(fz);
            tbl_len[pos-1] = (sum > LEN_TOP) ? LEN_TOP[16:0] : sum[16:0];
            r = '{ST_MERGED_BEFORE, tbl_start[pos-1], tbl_len[pos-1], 7'(tbl_count)};
        end else if (touch_next) begin
            sum = int'(tbl_len[pos]) + int'(fz);
            tbl_start[pos] = fs;
            tbl_len[pos]   = (sum > LEN_TOP) ? LEN_TOP[16:0] : sum[16:0];
            r = '{ST_MERGED_AFTER, tbl_start[pos], tbl_len[pos], 7'(tbl_count)};
        end else if (tbl_count >= MAX_EXT) begin
            r = '{ST_FULL_DROP, 16'd0, 17'd0, 7'(tbl_count)};
        end else begin
            for (int i = tbl_count; i > pos; i--) begin
                tbl_start[i] = tbl_start[i-1];
                tbl_len[i]   = tbl_len[i-1];
            end
            tbl_start[pos] = fs;
            tbl_len[pos]   = {1'b0, fz};
            tbl_count++;
            r = '{ST_INSERTED, fs, {1'b0, fz}, 7'(tbl_count)};
        end
        return r;
    endfunction

    // Present one free, hold it until the transfer, then queue its result.
    task automatic send_free(logic [15:0] fs, logic [15:0] fz, bit typed, t_outcome want);
        t_outcome r;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fz, fs};
        do @(posedge i_clk); while (!s_axis_tready);
        r = coalesce_free(fs, fz);
        // Rows typed in by hand still advance the shadow table
        pending_results.push_back(typed ? want : r);
        n_sent++;
    endtask

    // Pick a free: mostly shapes that merge or fill the table, some pure noise.
    task automatic pick_free(output logic [15:0] fs, output logic [15:0] fz);
        int mode;
        int k;
        int tail;
        mode = $urandom_range(0, 99);
        fs = 16'($urandom_range(0, 65535));
        fz = 16'($urandom_range(0, 65535));
        if (mode < 35) begin
            fs = 16'($urandom_range(0, 1023) * 64);
            fz = 16'd64;
        end else if (mode < 65) begin
            fs = 16'($urandom_range(0, 511) * 128);
            fz = 16'($urandom_range(1, 100));
        end else if (mode < 90 && tbl_count > 0) begin
            // Free right behind an existing extent, sometimes closing the hole
            k = $urandom_range(0, tbl_count - 1);
            tail = int'(tbl_start[k]) + int'(tbl_len[k]);
            if (tail <= 65535) begin
                fs = 16'(tail);
                fz = 16'($urandom_range(1, 200));
                if (k + 1 < tbl_count && int'(tbl_start[k+1]) > tail &&
                    $urandom_range(0, 1) == 0)
                    fz = 16'(int'(tbl_start[k+1]) - tail);
            end
        end
    endtask

    // Receiver: stall in bursts, stay ready for the tail of the run
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                n = $urandom_range(1, 20);
                m_axis_tready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Compare each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[2:0]);
            got.start  = m_axis_tdata[18:3];
            got.length = m_axis_tdata[35:19];
            got.total  = m_axis_tdata[42:36];
            n_recv++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: got %p", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) begin
                    $display("%0t status: expected %0d, got %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.start != want.start) begin
                    $display("%0t result_start: expected %0d, got %0d", $time,
                             want.start, got.start);
                    errors++;
                end
                if (got.length != want.length) begin
                    $display("%0t result_length: expected %0d, got %0d", $time,
                             want.length, got.length);
                    errors++;
                end
                if (got.total != want.total) begin
                    $display("%0t extent_total: expected %0d, got %0d", $time,
                             want.total, got.total);
                    errors++;
                end
                if (want.status == ST_FULL_DROP) n_dropped++;
                else if (want.status != ST_INSERTED) n_merged++;
            end
        end
    end

    initial begin
        t_row rows[$];
        logic [15:0] fs;
        logic [15:0] fz;
        int wait_cycles;
        // Hand-checked opening: inserts at both ends, merges each way, zero size
        rows = '{
            '{16'd100,   16'd10,    1'b1, '{ST_INSERTED,      16'd100,   17'd10,     7'd1}},
            '{16'd0,     16'd1,     1'b1, '{ST_INSERTED,      16'd0,     17'd1,      7'd2}},
            '{16'd65535, 16'd65535, 1'b1, '{ST_INSERTED,      16'd65535, 17'd65535,  7'd3}},
            '{16'd110,   16'd5,     1'b1, '{ST_MERGED_BEFORE, 16'd100,   17'd15,     7'd3}},
            '{16'd90,    16'd10,    1'b1, '{ST_MERGED_AFTER,  16'd90,    17'd25,     7'd3}},
            '{16'd1,     16'd89,    1'b1, '{ST_MERGED_BOTH,   16'd0,     17'd115,    7'd2}},
            '{16'd200,   16'd0,     1'b1, '{ST_INSERTED,      16'd200,   17'd0,      7'd3}},
            '{16'd200,   16'd0,     1'b1, '{ST_MERGED_AFTER,  16'd200,   17'd0,      7'd3}},
            '{16'd115,   16'd85,    1'b1, '{ST_MERGED_BOTH,   16'd0,     17'd200,    7'd2}},
            '{16'd200,   16'd65335, 1'b1, '{ST_MERGED_BOTH,   16'd0,     17'd131070, 7'd1}},
            '{16'd65535, 16'd1,     1'b0, '0},
            '{16'd32768, 16'd32767, 1'b0, '0},
            '{16'd65534, 16'd1,     1'b0, '0},
            '{16'd0,     16'd65535, 1'b0, '0}
        };
        errors = 0; n_sent = 0; n_recv = 0; n_merged = 0; n_dropped = 0;
        quiet = 1'b0;
        tbl_count = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_free(rows[i].start, rows[i].size, rows[i].typed,
                                    rows[i].outcome);

        for (int i = 0; i < N_RAND; i++) begin
            if (i == N_RAND - N_QUIET) quiet = 1'b1;
            pick_free(fs, fz);
            send_free(fs, fz, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block room to show anything extra
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (2 * MAX_EXT + 20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_results.size());
            errors++;
        end

        $display("Sent %0d frees, got %0d results: %0d merges, %0d drops on a full table",
                 n_sent, n_recv, n_merged, n_dropped);
        $display("Mismatches: %0d, extents held at end: %0d", errors, tbl_count);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
